### rtl/core/mtc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtc_pkg
// shared types, character codes and morse tables for the text codec
// ----------------------------------------------------------------------------
package mtc_pkg;

   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_DASH    = 8'h2D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] LETTER_FIRST = 8'd65;
   localparam logic [7:0] LETTER_LAST  = 8'd90;

   localparam logic [2:0] GROUP_MAX    = 3'd4;
   localparam logic [2:0] GROUP_OVER   = 3'd5;
   localparam logic [1:0] RUN_WORD     = 2'd3;
   localparam logic [2:0] TAIL_LETTER  = 3'd1;
   localparam logic [2:0] TAIL_OTHER   = 3'd4;

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   localparam int NUM_LETTERS   = 26;
   localparam int QUEUE_DEPTH   = 2;

   // pattern msb-first, dash = 1
   localparam logic [3:0] CODE_BITS [NUM_LETTERS] = '{
      4'h1, 4'h8, 4'hA, 4'h4, 4'h0, 4'h2, 4'h6, 4'h0, 4'h0, 4'h7, 4'h5, 4'h4, 4'h3,
      4'h2, 4'h7, 4'h6, 4'hD, 4'h2, 4'h0, 4'h1, 4'h1, 4'h1, 4'h3, 4'h9, 4'hB, 4'hC
   };
   localparam logic [2:0] CODE_LEN [NUM_LETTERS] = '{
      3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
      3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
   };

   // one run of output: optional head char, then symbols, then spaces
   typedef struct packed {
      logic       head_en;
      logic [7:0] head_char;
      logic [2:0] sym_count;
      logic [3:0] pattern;
      logic [2:0] tail_count;
   } cmd_type;

   typedef struct packed {
      logic       found;
      logic [7:0] letter;
   } lookup_type;

   function automatic lookup_type lookup_letter(input logic [2:0] len,
                                                input logic [3:0] pat);
      lookup_type res;
      res.found  = 1'b0;
      res.letter = LETTER_FIRST;
      for (int i = NUM_LETTERS - 1; i >= 0; i--) begin
         if (CODE_LEN[i] == len && CODE_BITS[i] == pat) begin
            res.found  = 1'b1;
            res.letter = LETTER_FIRST + 8'(i);
         end
      end
      return res;
   endfunction

endpackage
`default_nettype wire

### rtl/core/mtc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtc_front
// takes input characters, keeps the decoder state and issues run commands
// ----------------------------------------------------------------------------
module mtc_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   input  wire logic             csr_data,
   input  wire logic             accept,
   input  wire logic [7:0]       in_char,
   output mtc_pkg::cmd_type      cmd,
   output logic                  cmd_valid
);

   logic       direction_ff, direction_in;
   logic [3:0] pattern_ff, pattern_in;
   logic [2:0] length_ff, length_in;
   logic [1:0] run_ff, run_in;

   logic                 is_letter;
   logic [4:0]           letter_idx;
   mtc_pkg::lookup_type  found;

   assign is_letter  = (in_char >= mtc_pkg::LETTER_FIRST) && (in_char <= mtc_pkg::LETTER_LAST);
   assign letter_idx = 5'(in_char - mtc_pkg::LETTER_FIRST);
   assign found      = mtc_pkg::lookup_letter(length_ff, pattern_ff);

   always_comb begin
      direction_in = csr_valid ? csr_data : direction_ff;
      pattern_in   = pattern_ff;
      length_in    = length_ff;
      run_in       = run_ff;
      cmd          = '0;
      cmd_valid    = 1'b0;
      if (direction_ff == mtc_pkg::DIR_ENCODE) begin
         cmd_valid = accept;
         if (is_letter) begin
            cmd.sym_count  = mtc_pkg::CODE_LEN[letter_idx];
            cmd.pattern    = mtc_pkg::CODE_BITS[letter_idx];
            cmd.tail_count = mtc_pkg::TAIL_LETTER;
         end else begin
            cmd.head_en    = 1'b1;
            cmd.head_char  = in_char;
            cmd.tail_count = mtc_pkg::TAIL_OTHER;
         end
      end else if (in_char == mtc_pkg::CHAR_DOT || in_char == mtc_pkg::CHAR_DASH) begin
         run_in = '0;
         if (length_ff < mtc_pkg::GROUP_MAX) begin
            pattern_in = {pattern_ff[2:0], in_char == mtc_pkg::CHAR_DASH};
            length_in  = length_ff + 3'd1;
         end else begin
            length_in  = mtc_pkg::GROUP_OVER;
         end
      end else if (in_char == mtc_pkg::CHAR_SPACE) begin
         pattern_in = '0;
         length_in  = '0;
         // over-long or empty groups never match the table
         cmd.head_en   = found.found;
         cmd.head_char = found.letter;
         if (run_ff < mtc_pkg::RUN_WORD) begin
            run_in = run_ff + 2'd1;
            // third space of a run gives a word space
            if (run_ff == mtc_pkg::RUN_WORD - 2'd1) cmd.tail_count = 3'd1;
         end
         cmd_valid = accept && (cmd.head_en || cmd.tail_count != '0);
      end else begin
         run_in        = '0;
         cmd.head_en   = 1'b1;
         cmd.head_char = in_char;
         cmd_valid     = accept;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= mtc_pkg::DIR_ENCODE;
         pattern_ff   <= '0;
         length_ff    <= '0;
         run_ff       <= '0;
      end else begin
         direction_ff <= direction_in;
         if (accept) begin
            pattern_ff <= pattern_in;
            length_ff  <= length_in;
            run_ff     <= run_in;
         end
      end
   end

endmodule
`default_nettype wire

### rtl/core/mtc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtc_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module mtc_queue #(
   parameter int DEPTH = mtc_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire mtc_pkg::cmd_type  push_cmd,
   output logic                   space_avail,
   input  wire logic              pop,
   output mtc_pkg::cmd_type       head_cmd,
   output logic                   head_valid
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   mtc_pkg::cmd_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign space_avail = (count_ff != FULL_CNT);
   assign head_valid  = (count_ff != '0);
   assign head_cmd    = entries_ff[rd_ptr_ff];
   assign do_push     = push && space_avail;
   assign do_pop      = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      else if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/mtc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtc_back
// expands run commands into output characters, one per cycle while the output is not stalled
// ----------------------------------------------------------------------------
module mtc_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mtc_pkg::cmd_type  head_cmd,
   input  wire logic              head_valid,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tlast
);

   logic       busy_ff, busy_in;
   logic       head_en_ff, head_en_in;
   logic [7:0] head_char_ff, head_char_in;
   logic [2:0] sym_left_ff, sym_left_in;
   logic [3:0] pat_ff, pat_in;
   logic [2:0] tail_left_ff, tail_left_in;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_char_ff, out_char_in;
   logic       out_last_ff, out_last_in;

   logic       out_free, emit, emit_last;
   logic [1:0] bit_idx;
   logic [7:0] next_char;

   assign out_free = !out_valid_ff || rsp_tready;
   assign emit     = busy_ff && out_free;
   assign bit_idx  = 2'(sym_left_ff - 3'd1);

   always_comb begin
      if (head_en_ff) begin
         next_char = head_char_ff;
         emit_last = (sym_left_ff == '0) && (tail_left_ff == '0);
      end else if (sym_left_ff != '0) begin
         next_char = pat_ff[bit_idx] ? mtc_pkg::CHAR_DASH : mtc_pkg::CHAR_DOT;
         emit_last = (sym_left_ff == 3'd1) && (tail_left_ff == '0);
      end else begin
         next_char = mtc_pkg::CHAR_SPACE;
         emit_last = (tail_left_ff == 3'd1);
      end
   end

   assign pop = head_valid && (!busy_ff || (emit && emit_last));

   always_comb begin
      busy_in      = busy_ff;
      head_en_in   = head_en_ff;
      head_char_in = head_char_ff;
      sym_left_in  = sym_left_ff;
      pat_in       = pat_ff;
      tail_left_in = tail_left_ff;
      if (emit) begin
         if (head_en_ff)              head_en_in   = 1'b0;
         else if (sym_left_ff != '0)  sym_left_in  = sym_left_ff - 3'd1;
         else                         tail_left_in = tail_left_ff - 3'd1;
         if (emit_last) busy_in = 1'b0;
      end
      if (pop) begin
         busy_in      = 1'b1;
         head_en_in   = head_cmd.head_en;
         head_char_in = head_cmd.head_char;
         sym_left_in  = head_cmd.sym_count;
         pat_in       = head_cmd.pattern;
         tail_left_in = head_cmd.tail_count;
      end
      out_valid_in = out_free ? emit : out_valid_ff;
      out_char_in  = emit ? next_char : out_char_ff;
      out_last_in  = emit ? emit_last : out_last_ff;
   end

   always_ff @(posedge clock) begin
      head_char_ff <= head_char_in;
      pat_ff       <= pat_in;
      out_char_ff  <= out_char_in;
      out_last_ff  <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         head_en_ff   <= 1'b0;
         sym_left_ff  <= '0;
         tail_left_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         head_en_ff   <= head_en_in;
         sym_left_ff  <= sym_left_in;
         tail_left_ff <= tail_left_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
`default_nettype wire

### rtl/core/morse_text_codec_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// morse_text_codec_core
// ascii to international morse text converter, both directions
// ----------------------------------------------------------------------------
// One ASCII byte is taken per req transfer and expands into zero to five
// rsp transfers, the final one flagged by rsp_tlast. In encode mode a
// letter A-Z becomes dots and dashes plus one space, any other byte passes
// through followed by four spaces. In decode mode dots and dashes gather
// into a group, a space emits the matching letter and the third space of a
// run emits a word space; other bytes pass through. The output runs at one
// character per cycle while rsp_tready holds, set by the back end that
// expands each command, and the queue lets new bytes be taken while earlier
// ones still expand. The direction is written over the csr channel; the user
// must write it only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module morse_text_codec_core #(
   parameter int QUEUE_DEPTH = mtc_pkg::QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // configuration write channel
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_data,     // direction: 0 encode, 1 decode
   // input characters
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,    // [7:0] in_char
   // output characters
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,    // [7:0] out_char
   output logic            rsp_tlast     // last_of_run
);

   mtc_pkg::cmd_type front_cmd;
   mtc_pkg::cmd_type queue_head;
   logic             front_cmd_valid;
   logic             queue_space;
   logic             queue_head_valid;
   logic             queue_pop;
   logic             req_accept;

   // register writes are always taken
   assign csr_ready  = 1'b1;

   // the front stalls only when the queue cannot take a command
   assign req_tready = queue_space;
   assign req_accept = req_tvalid && req_tready;

   // front: classify the character, update the group state
   mtc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .accept    (req_accept),
      .in_char   (req_tdata),
      .cmd       (front_cmd),
      .cmd_valid (front_cmd_valid)
   );

   // queue of run commands so front and back stall separately
   mtc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (front_cmd_valid),
      .push_cmd    (front_cmd),
      .space_avail (queue_space),
      .pop         (queue_pop),
      .head_cmd    (queue_head),
      .head_valid  (queue_head_valid)
   );

   // back: one output character per cycle, when not stalled, into the output register
   mtc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (queue_head),
      .head_valid (queue_head_valid),
      .pop        (queue_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire
